[hdl/pfhd_pkg.sv]
// Package for the packet flow hash dispatcher.
// Types, codes and constants shared by the controller, the datapath and the top level.
// No dependencies.
`default_nettype none

package pfhd_pkg;

  localparam int unsigned DEF_MAX_WORKERS = 256;
  localparam int unsigned HASH_W          = 32;
  localparam int unsigned STEP_CNT_W      = $clog2(HASH_W);

  localparam logic [15:0] MIN_PKT_LEN   = 16'd34;
  localparam logic [15:0] ETH_HDR_LEN   = 16'd14;
  localparam logic [15:0] BYTE_CNT_MAX  = 16'hFFFF;
  localparam logic [15:0] ETYPE_VLAN    = 16'h8100;
  localparam logic [15:0] ETYPE_QINQ    = 16'h88a8;
  localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6    = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [16:0] IPV4_HDR_LEN  = 17'd20;
  localparam logic [16:0] IPV6_HDR_LEN  = 17'd40;
  localparam logic [16:0] TAG_LEN       = 17'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_HASH_SEED    = 2'd0;
  localparam logic [1:0] CFG_WORKER_COUNT = 2'd1;

  // result kind codes
  localparam logic [2:0] KIND_SHORT      = 3'd0;
  localparam logic [2:0] KIND_NON_IP     = 3'd1;
  localparam logic [2:0] KIND_IPV4_TRUNC = 3'd2;
  localparam logic [2:0] KIND_IPV4       = 3'd3;
  localparam logic [2:0] KIND_IPV4_PORTS = 3'd4;
  localparam logic [2:0] KIND_IPV6       = 3'd5;
  localparam logic [2:0] KIND_IPV6_TRUNC = 3'd6;

  typedef enum logic [2:0] {
    PH_ETHER = 3'd0,
    PH_OTHER = 3'd1,
    PH_IPV4  = 3'd2,
    PH_IPV6  = 3'd3,
    PH_OVER  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_PARSE   = 2'd0,
    ST_CLOSE   = 2'd1,
    ST_DIVIDE  = 2'd2,
    ST_DELIVER = 2'd3
  } ctl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic byte_en;   // parse the item on the input channel
    logic close_en;  // finish the packet: build hash and kind, start the modulo
    logic div_en;    // one restoring step of the modulo
  } dp_cmd_t;

endpackage

`default_nettype wire

[hdl/pfhd_ctrl.sv]
// Controller of the packet flow hash dispatcher.
// Sequences byte parsing, packet close, the 32 modulo steps and result delivery.
// Depends on pfhd_pkg.
`default_nettype none

module pfhd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_last,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output pfhd_pkg::dp_cmd_t    cmd
);

  localparam logic [pfhd_pkg::STEP_CNT_W-1:0] STEP_LAST =
    pfhd_pkg::STEP_CNT_W'(pfhd_pkg::HASH_W - 1);

  pfhd_pkg::ctl_state_t             state_r, state_nxt;
  logic [pfhd_pkg::STEP_CNT_W-1:0]  step_r, step_nxt;
  logic                             in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfhd_pkg::ST_PARSE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    // bytes of the next packet may arrive during the modulo, where only a last byte waits; all wait in close
    in_stall  = (state_r == pfhd_pkg::ST_CLOSE) ||
                (in_last && (state_r != pfhd_pkg::ST_PARSE));
    in_acc    = in_valid && !in_stall;
    out_valid = (state_r == pfhd_pkg::ST_DELIVER);
    cmd.byte_en  = in_acc;
    cmd.close_en = (state_r == pfhd_pkg::ST_CLOSE);
    cmd.div_en   = (state_r == pfhd_pkg::ST_DIVIDE);
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      pfhd_pkg::ST_PARSE: begin
        if (in_acc && in_last) state_nxt = pfhd_pkg::ST_CLOSE;
      end
      pfhd_pkg::ST_CLOSE: begin
        step_nxt  = '0;
        state_nxt = pfhd_pkg::ST_DIVIDE;
      end
      pfhd_pkg::ST_DIVIDE: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_LAST) state_nxt = pfhd_pkg::ST_DELIVER;
      end
      pfhd_pkg::ST_DELIVER: begin
        if (!out_stall) state_nxt = pfhd_pkg::ST_PARSE;
      end
      default: begin
        state_nxt = pfhd_pkg::ST_PARSE;
      end
    endcase
  end

  a_last_only_in_parse: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last) |-> (state_r == pfhd_pkg::ST_PARSE))
    else $error("last byte accepted outside parse state");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last) |=> (state_r == pfhd_pkg::ST_CLOSE))
    else $error("last byte did not start packet close");

  a_close_starts_divide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pfhd_pkg::ST_CLOSE) |=> (state_r == pfhd_pkg::ST_DIVIDE && step_r == '0))
    else $error("close did not start a fresh modulo");

  a_divide_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pfhd_pkg::ST_DIVIDE && step_r == STEP_LAST)
      |=> (state_r == pfhd_pkg::ST_DELIVER))
    else $error("modulo did not end after its last step");

endmodule

`default_nettype wire

[hdl/pfhd_datapath.sv]
// Datapath of the packet flow hash dispatcher.
// Config registers, byte parser state, hash and kind build, restoring modulo unit.
// Depends on pfhd_pkg.
`default_nettype none

module pfhd_datapath #(
  parameter int unsigned MAX_WORKERS = pfhd_pkg::DEF_MAX_WORKERS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pfhd_pkg::dp_cmd_t cmd,
  input  wire logic              cfg_wr_en,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire logic [7:0]        in_pkt_byte,
  output logic [31:0]            out_flow_hash,
  output logic [7:0]             out_worker_index,
  output logic [2:0]             out_kind
);

  localparam int unsigned NW = $clog2(MAX_WORKERS + 1);  // effective worker count
  localparam int unsigned RW = $clog2(MAX_WORKERS);      // remainder

  // configuration
  logic [31:0] hash_seed_r;
  logic [8:0]  worker_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_seed_r    <= '0;
      worker_count_r <= 9'd1;
    end else if (cfg_wr_en) begin
      if (cfg_index == pfhd_pkg::CFG_HASH_SEED) hash_seed_r <= cfg_data;
      if (cfg_index == pfhd_pkg::CFG_WORKER_COUNT) worker_count_r <= cfg_data[8:0];
    end
  end

  // per-packet parser state
  logic [15:0]      byte_count_r, byte_count_nxt;
  logic [15:0]      ether_type_r, ether_type_nxt;
  logic [15:0]      net_off_r, net_off_nxt;
  logic [5:0]       hdr_len_r, hdr_len_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [31:0]      gather_r, gather_nxt;
  logic [31:0]      addr_hash_r, addr_hash_nxt;
  logic [31:0]      port_pair_r, port_pair_nxt;
  pfhd_pkg::phase_t phase_r, phase_nxt;

  logic [16:0] pos17, off17, hl17;
  logic [15:0] rel;
  logic        in_net;

  always_comb begin
    byte_count_nxt = byte_count_r;
    ether_type_nxt = ether_type_r;
    net_off_nxt    = net_off_r;
    hdr_len_nxt    = hdr_len_r;
    proto_nxt      = proto_r;
    gather_nxt     = gather_r;
    addr_hash_nxt  = addr_hash_r;
    port_pair_nxt  = port_pair_r;
    phase_nxt      = phase_r;
    pos17  = {1'b0, byte_count_r};
    off17  = {1'b0, net_off_r};
    hl17   = {11'd0, hdr_len_r};
    in_net = (byte_count_r >= net_off_r);
    rel    = byte_count_r - net_off_r;

    if (cmd.close_en) begin
      byte_count_nxt = '0;
      ether_type_nxt = '0;
      net_off_nxt    = pfhd_pkg::ETH_HDR_LEN;
      hdr_len_nxt    = '0;
      proto_nxt      = '0;
      gather_nxt     = '0;
      addr_hash_nxt  = '0;
      port_pair_nxt  = '0;
      phase_nxt      = pfhd_pkg::PH_ETHER;
    end else if (cmd.byte_en && (byte_count_r != pfhd_pkg::BYTE_CNT_MAX)) begin
      byte_count_nxt = byte_count_r + 16'd1;
      if (phase_r == pfhd_pkg::PH_ETHER) begin
        if ((pos17 + 17'd2 == off17) || (pos17 + 17'd1 == off17))
          ether_type_nxt = {ether_type_r[7:0], in_pkt_byte};
        if (pos17 + 17'd1 == off17) begin
          if (ether_type_nxt == pfhd_pkg::ETYPE_VLAN ||
              ether_type_nxt == pfhd_pkg::ETYPE_QINQ) begin
            if (off17 + pfhd_pkg::TAG_LEN > {1'b0, pfhd_pkg::BYTE_CNT_MAX})
              phase_nxt = pfhd_pkg::PH_OVER;
            else
              net_off_nxt = net_off_r + 16'd4;
          end else if (ether_type_nxt == pfhd_pkg::ETYPE_IPV4) begin
            phase_nxt = pfhd_pkg::PH_IPV4;
          end else if (ether_type_nxt == pfhd_pkg::ETYPE_IPV6) begin
            phase_nxt = pfhd_pkg::PH_IPV6;
          end else begin
            phase_nxt = pfhd_pkg::PH_OTHER;
          end
        end
      end else if (in_net && phase_r == pfhd_pkg::PH_IPV4) begin
        if (rel == 16'd0) hdr_len_nxt = {in_pkt_byte[3:0], 2'b00};
        if (rel == 16'd9) proto_nxt = in_pkt_byte;
        if (rel >= 16'd12 && rel <= 16'd19) gather_nxt = {in_pkt_byte, gather_r[31:8]};
        if (rel == 16'd15 || rel == 16'd19) addr_hash_nxt = addr_hash_r ^ gather_nxt;
        if ({1'b0, rel} >= hl17 && {1'b0, rel} < hl17 + 17'd4)
          port_pair_nxt = {port_pair_r[23:0], in_pkt_byte};
      end else if (in_net && phase_r == pfhd_pkg::PH_IPV6) begin
        if (rel >= 16'd8 && rel <= 16'd39) begin
          gather_nxt = {in_pkt_byte, gather_r[31:8]};
          // word complete on every fourth byte from the source address on
          if (rel >= 16'd11 && rel[1:0] == 2'b11) addr_hash_nxt = addr_hash_r ^ gather_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      ether_type_r <= '0;
      net_off_r    <= pfhd_pkg::ETH_HDR_LEN;
      hdr_len_r    <= '0;
      proto_r      <= '0;
      gather_r     <= '0;
      addr_hash_r  <= '0;
      port_pair_r  <= '0;
      phase_r      <= pfhd_pkg::PH_ETHER;
    end else begin
      byte_count_r <= byte_count_nxt;
      ether_type_r <= ether_type_nxt;
      net_off_r    <= net_off_nxt;
      hdr_len_r    <= hdr_len_nxt;
      proto_r      <= proto_nxt;
      gather_r     <= gather_nxt;
      addr_hash_r  <= addr_hash_nxt;
      port_pair_r  <= port_pair_nxt;
      phase_r      <= phase_nxt;
    end
  end

  // packet close: hash and kind from the final parser state
  logic [31:0]   fin_hash;
  logic [2:0]    fin_kind;
  logic [16:0]   len17;
  logic [NW-1:0] eff_n;

  always_comb begin
    len17    = {1'b0, byte_count_r};
    fin_hash = '0;
    fin_kind = pfhd_pkg::KIND_SHORT;
    if (byte_count_r < pfhd_pkg::MIN_PKT_LEN) begin
      fin_hash = '0;
      fin_kind = pfhd_pkg::KIND_SHORT;
    end else if (phase_r == pfhd_pkg::PH_OTHER) begin
      fin_hash = hash_seed_r;
      fin_kind = pfhd_pkg::KIND_NON_IP;
    end else if (phase_r == pfhd_pkg::PH_IPV4) begin
      if (len17 < off17 + pfhd_pkg::IPV4_HDR_LEN) begin
        fin_hash = hash_seed_r;
        fin_kind = pfhd_pkg::KIND_IPV4_TRUNC;
      end else begin
        fin_hash = addr_hash_r ^ {8'd0, proto_r, 16'd0} ^ hash_seed_r;
        fin_kind = pfhd_pkg::KIND_IPV4;
        if ((proto_r == pfhd_pkg::PROTO_TCP || proto_r == pfhd_pkg::PROTO_UDP) &&
            len17 >= off17 + hl17 + 17'd4) begin
          fin_hash = fin_hash ^ port_pair_r;
          fin_kind = pfhd_pkg::KIND_IPV4_PORTS;
        end
      end
    end else if (phase_r == pfhd_pkg::PH_IPV6) begin
      if (len17 < off17 + pfhd_pkg::IPV6_HDR_LEN) begin
        fin_hash = hash_seed_r;
        fin_kind = pfhd_pkg::KIND_IPV6_TRUNC;
      end else begin
        fin_hash = addr_hash_r ^ hash_seed_r;
        fin_kind = pfhd_pkg::KIND_IPV6;
      end
    end
    if (worker_count_r > 9'(MAX_WORKERS))
      eff_n = NW'(MAX_WORKERS);
    else
      eff_n = NW'(worker_count_r);
  end

  // restoring modulo, one dividend bit per step, MSB first
  logic [31:0]   hash_r, dvd_r;
  logic [2:0]    kind_r;
  logic [NW-1:0] div_n_r;
  logic          n_zero_r;
  logic [RW-1:0] rem_r;
  logic [RW:0]   trial;
  logic          ge;

  always_comb begin
    trial = {rem_r, dvd_r[31]};
    ge    = (trial >= (RW + 1)'(div_n_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.close_en) begin
      hash_r   <= fin_hash;
      dvd_r    <= fin_hash;
      kind_r   <= fin_kind;
      div_n_r  <= eff_n;
      n_zero_r <= (eff_n == '0);
      rem_r    <= '0;
    end else if (cmd.div_en) begin
      dvd_r <= {dvd_r[30:0], 1'b0};
      rem_r <= ge ? RW'(trial - (RW + 1)'(div_n_r)) : RW'(trial);
    end
  end

  assign out_flow_hash    = hash_r;
  assign out_kind         = kind_r;
  assign out_worker_index = n_zero_r ? 8'd0 : 8'(rem_r);

endmodule

`default_nettype wire

[hdl/packet_flow_hash_dispatch_top.sv]
// Top level of the packet flow hash dispatcher.
// Instantiates pfhd_ctrl and pfhd_datapath; uses pfhd_pkg.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall | in_pkt_byte[7:0], in_last
//   out     | output    | out_valid/out_stall | out_flow_hash[31:0], out_worker_index[7:0],
//           |           |                     | out_kind[2:0]
//   cfg     | input     | cfg_valid/cfg_ready | cfg_index[1:0], cfg_data[31:0]
//
// The last byte is followed by the close state and the steps of the bit-serial modulo unit,
// then the result waits in the output register. Bytes of the next packet are taken during
// the modulo and while the result waits; that packet's last byte is held off until the
// result has been taken.
// Reset (rst_n low, synchronous) clears parser state and sets hash_seed 0, worker_count 1.
// cfg_ready is always high.
`default_nettype none

module packet_flow_hash_dispatch_top #(
  parameter int unsigned MAX_WORKERS = pfhd_pkg::DEF_MAX_WORKERS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_pkt_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_flow_hash,
  output logic [7:0]       out_worker_index,
  output logic [2:0]       out_kind,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  pfhd_pkg::dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  pfhd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  pfhd_datapath #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_wr_en        (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_pkt_byte      (in_pkt_byte),
    .out_flow_hash    (out_flow_hash),
    .out_worker_index (out_worker_index),
    .out_kind         (out_kind)
  );

endmodule

`default_nettype wire

[tb/packet_flow_hash_dispatch_top_test.sv]
// Self-checking testbench for packet_flow_hash_dispatch_top: frames go in byte by byte and
// each flow hash result is checked against a predictor of the header parser kept here.
// Depends on pfhd_pkg and the RTL of the block only.

module packet_flow_hash_dispatch_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pfhd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned DRAIN_WAIT  = 48;   // covers close, the modulo steps and slack
  localparam int          PHASE_BYTES = 30;   // random bytes per later phase, at least

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pkt_item_t;

  typedef struct packed {
    logic [31:0] flow_hash;
    logic [7:0]  worker_index;
    logic [2:0]  kind;
  } flow_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_pkt_byte = 8'h00;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_flow_hash;
  logic [7:0]  out_worker_index;
  logic [2:0]  out_kind;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_HASH_SEED;
  logic [31:0] cfg_data = 32'h0;

  pkt_item_t    byte_q[$];
  flow_result_t flow_expect_q[$];
  int unsigned  bytes_pending = 0;
  int unsigned  err_count = 0;
  int unsigned  cycle_cnt = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;

  // register mirror
  logic [31:0] seed_cfg = 32'h0;
  logic [8:0]  workers_cfg = 9'd1;

  // per-packet parser state
  logic [15:0] pkt_len;
  logic [15:0] etype_acc;
  logic [15:0] net_off;
  logic [5:0]  ihl_bytes;
  logic [7:0]  ip_proto;
  logic [31:0] word_acc;
  logic [31:0] addr_xor;
  logic [31:0] port_word;
  phase_t      hdr_phase;

  packet_flow_hash_dispatch_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pkt_byte      (in_pkt_byte),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_flow_hash    (out_flow_hash),
    .out_worker_index (out_worker_index),
    .out_kind         (out_kind),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void clear_flow_state();
    pkt_len   = 16'd0;
    etype_acc = 16'd0;
    net_off   = ETH_HDR_LEN;
    ihl_bytes = 6'd0;
    ip_proto  = 8'd0;
    word_acc  = 32'd0;
    addr_xor  = 32'd0;
    port_word = 32'd0;
    hdr_phase = PH_ETHER;
  endfunction

  // Advances the parser by one frame byte; returns 1 with the result at the last byte.
  function automatic bit hash_frame_byte(input logic [7:0] b, input logic last,
                                         output flow_result_t res);
    int unsigned pos, off, r, hl, len, n;
    logic [31:0] h;
    logic [2:0]  k;
    res = '0;
    if (pkt_len != BYTE_CNT_MAX) begin
      pos = pkt_len;
      off = net_off;
      pkt_len = pkt_len + 16'd1;
      if (hdr_phase == PH_ETHER) begin
        if (pos + 2 == off || pos + 1 == off)
          etype_acc = {etype_acc[7:0], b};
        if (pos + 1 == off) begin
          if (etype_acc == ETYPE_VLAN || etype_acc == ETYPE_QINQ) begin
            if (off + 4 > 32'hFFFF)
              hdr_phase = PH_OVER;
            else
              net_off = net_off + 16'd4;
          end else if (etype_acc == ETYPE_IPV4) begin
            hdr_phase = PH_IPV4;
          end else if (etype_acc == ETYPE_IPV6) begin
            hdr_phase = PH_IPV6;
          end else begin
            hdr_phase = PH_OTHER;
          end
        end
      end else if (pos >= off) begin
        r = pos - off;
        if (hdr_phase == PH_IPV4) begin
          if (r == 0)
            ihl_bytes = {b[3:0], 2'b00};
          if (r == 9)
            ip_proto = b;
          // addresses gathered little-endian
          if (r >= 12 && r <= 19)
            word_acc = {b, word_acc[31:8]};
          if (r == 15 || r == 19)
            addr_xor ^= word_acc;
          hl = ihl_bytes;
          if (r >= hl && r < hl + 4)
            port_word = {port_word[23:0], b};
        end else if (hdr_phase == PH_IPV6 && r >= 8 && r <= 39) begin
          word_acc = {b, word_acc[31:8]};
          if (r >= 11 && ((r - 11) & 3) == 0)
            addr_xor ^= word_acc;
        end
      end
    end
    if (!last)
      return 1'b0;

    len = pkt_len;
    off = net_off;
    if (len < MIN_PKT_LEN || hdr_phase == PH_ETHER || hdr_phase == PH_OVER) begin
      h = 32'h0;
      k = KIND_SHORT;
    end else if (hdr_phase == PH_OTHER) begin
      h = seed_cfg;
      k = KIND_NON_IP;
    end else if (hdr_phase == PH_IPV4) begin
      if (len < off + 20) begin
        h = seed_cfg;
        k = KIND_IPV4_TRUNC;
      end else begin
        h = addr_xor ^ {8'h00, ip_proto, 16'h0000};
        k = KIND_IPV4;
        if ((ip_proto == PROTO_TCP || ip_proto == PROTO_UDP) &&
            len >= off + ihl_bytes + 4) begin
          h ^= port_word;
          k = KIND_IPV4_PORTS;
        end
        h ^= seed_cfg;
      end
    end else begin
      if (len < off + 40) begin
        h = seed_cfg;
        k = KIND_IPV6_TRUNC;
      end else begin
        h = addr_xor ^ seed_cfg;
        k = KIND_IPV6;
      end
    end

    n = workers_cfg;
    if (n > DEF_MAX_WORKERS)
      n = DEF_MAX_WORKERS;
    res.flow_hash    = h;
    res.worker_index = (n == 0) ? 8'd0 : 8'(h % n);
    res.kind         = k;
    clear_flow_state();
    return 1'b1;
  endfunction

  task automatic log_error(input string msg);
    err_count++;
    if (err_count <= 10)
      $display("[%0t] %s", $realtime, msg);
  endtask

  // input side: one item per handshake, payload held while stalled
  always @(posedge clk) begin : drive_bytes
    pkt_item_t    nxt;
    flow_result_t res;
    if (!rst_n) begin
      in_valid    <= 1'b0;
      in_pkt_byte <= 8'h00;
      in_last     <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (hash_frame_byte(in_pkt_byte, in_last, res))
          flow_expect_q.push_back(res);
        bytes_pending--;
      end
      if (!in_valid || !in_stall) begin
        if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = byte_q.pop_front();
          in_valid    <= 1'b1;
          in_pkt_byte <= nxt.data;
          in_last     <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin : watch_results
    flow_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (flow_expect_q.size() == 0) begin
          log_error($sformatf("unexpected result hash %h index %0d kind %0d",
                              out_flow_hash, out_worker_index, out_kind));
        end else begin
          want = flow_expect_q.pop_front();
          if (out_flow_hash !== want.flow_hash || out_worker_index !== want.worker_index ||
              out_kind !== want.kind)
            log_error($sformatf(
              "mismatch: hash %h exp %h, index %0d exp %0d, kind %0d exp %0d",
              out_flow_hash, want.flow_hash, out_worker_index, want.worker_index,
              out_kind, want.kind));
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("packet_flow_hash_dispatch_top_test: errors");
      $finish;
    end
  end

  task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_HASH_SEED)
      seed_cfg = val;
    else
      workers_cfg = val[8:0];
  endtask

  // wait until every byte is taken and every result has come, then let the modulo settle
  task automatic settle();
    while (bytes_pending != 0 || flow_expect_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Ethernet frame with random MACs, a tag chain, a type and, for IPv4, the first header bytes; cut or padded to len.
  task automatic add_frame(input int tags, input logic [15:0] etype, input logic [3:0] ihl,
                           input logic [7:0] proto, input int len);
    logic [7:0] f[$];
    logic [7:0] v;
    pkt_item_t  it;
    f = {};
    repeat (12) f.push_back(8'($urandom));
    for (int i = 0; i < tags; i++) begin
      if ($urandom_range(0, 1)) begin
        f.push_back(ETYPE_VLAN[15:8]);
        f.push_back(ETYPE_VLAN[7:0]);
      end else begin
        f.push_back(ETYPE_QINQ[15:8]);
        f.push_back(ETYPE_QINQ[7:0]);
      end
      f.push_back(8'($urandom));
      f.push_back(8'($urandom));
    end
    f.push_back(etype[15:8]);
    f.push_back(etype[7:0]);
    if (etype == ETYPE_IPV4) begin
      v = 8'($urandom);
      f.push_back({v[7:4], ihl});
      repeat (8) f.push_back(8'($urandom));
      f.push_back(proto);
    end
    while (f.size() < len)
      f.push_back(8'($urandom));
    for (int i = 0; i < len; i++) begin
      it.data = f[i];
      it.last = (i == len - 1);
      byte_q.push_back(it);
      bytes_pending++;
    end
  endtask

  // mostly well-formed IPv4/IPv6 frames, plus non-IP, short, cut tag chains and noise
  task automatic add_random_frame(output int len);
    int          sel, tags, nominal, ports_end;
    logic [15:0] et;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    sel  = $urandom_range(0, 99);
    tags = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    ihl  = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
    case ($urandom_range(0, 2))
      0:       proto = PROTO_TCP;
      1:       proto = PROTO_UDP;
      default: proto = 8'($urandom);
    endcase
    if (sel < 40) begin
      et = ETYPE_IPV4;
      ports_end = int'(ihl) * 4 + 4;
      nominal = 14 + 4 * tags + ((ports_end > 20) ? ports_end : 20) + $urandom_range(0, 24);
    end else if (sel < 65) begin
      et = ETYPE_IPV6;
      nominal = 14 + 4 * tags + 40 + $urandom_range(0, 24);
    end else if (sel < 75) begin
      et = 16'($urandom);
      nominal = $urandom_range(34, 90);
    end else if (sel < 85) begin
      et = ETYPE_IPV4;
      nominal = $urandom_range(1, 33);
    end else if (sel < 92) begin
      // frame ends inside a long tag chain
      et = ETYPE_IPV4;
      tags = $urandom_range(6, 12);
      nominal = $urandom_range(34, 13 + 4 * tags);
    end else begin
      et = 16'($urandom);
      tags = 0;
      nominal = $urandom_range(1, 100);
    end
    len = nominal;
    if (sel < 65 && $urandom_range(0, 5) == 0)
      len = $urandom_range(34, nominal);
    add_frame(tags, et, ihl, proto, len);
  endtask

  initial begin : main_seq
    logic [31:0] seed_val;
    logic [31:0] count_val;
    int          nbytes, flen;
    clear_flow_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 7; ph++) begin
      settle();
      case (ph)
        0:       begin seed_val = 32'h9E37_79B9; count_val = 32'd7;   end
        1:       begin seed_val = 32'hFFFF_FFFF; count_val = 32'd256; end
        2:       begin seed_val = 32'h0;         count_val = 32'd1;   end
        3:       begin seed_val = $urandom;      count_val = 32'd0;   end
        4:       begin seed_val = $urandom;      count_val = 32'd511; end
        5:       begin seed_val = $urandom;      count_val = $urandom_range(2, 255); end
        default: begin seed_val = $urandom;      count_val = 32'd3;   end
      endcase
      write_cfg(CFG_HASH_SEED, seed_val);
      write_cfg(CFG_WORKER_COUNT, count_val);
      if (ph < 3) begin
        send_idle_pct = 21;
        recv_stall_pct = 62;
      end else if (ph < 5) begin
        send_idle_pct = 62;
        recv_stall_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end

      if (ph == 0) begin
        add_frame(0, ETYPE_IPV4, 4'd5, PROTO_TCP, 1);
        add_frame(0, ETYPE_IPV4, 4'd5, PROTO_TCP, 33);
        add_frame(0, ETYPE_IPV4, 4'd5, PROTO_TCP, 34);    // header only, no ports
        add_frame(0, ETYPE_IPV4, 4'd5, PROTO_TCP, 38);
        add_frame(0, ETYPE_IPV4, 4'd5, PROTO_UDP, 60);
        add_frame(0, ETYPE_IPV4, 4'd15, PROTO_UDP, 77);   // ports one byte short
        add_frame(0, ETYPE_IPV4, 4'd15, PROTO_UDP, 78);
        add_frame(0, ETYPE_IPV4, 4'd0, PROTO_TCP, 40);    // ports overlap the header
        add_frame(0, ETYPE_IPV4, 4'd5, 8'd1, 64);
        add_frame(0, ETYPE_IPV4, 4'd5, 8'hFF, 64);
        add_frame(1, ETYPE_IPV4, 4'd5, PROTO_UDP, 37);    // IPv4 header cut short
        add_frame(3, ETYPE_IPV4, 4'd5, PROTO_TCP, 80);
        add_frame(0, ETYPE_IPV6, 4'd0, 8'd0, 54);
        add_frame(0, ETYPE_IPV6, 4'd0, 8'd0, 53);
        add_frame(2, ETYPE_IPV6, 4'd0, 8'd0, 62);
        add_frame(0, 16'h0806, 4'd0, 8'd0, 60);
        add_frame(0, 16'h0000, 4'd0, 8'd0, 34);
        add_frame(0, 16'hFFFF, 4'd0, 8'd0, 34);
        add_frame(0, 16'h8101, 4'd0, 8'd0, 40);
        add_frame(8, ETYPE_IPV4, 4'd5, PROTO_TCP, 45);    // ends before inner type
      end else begin
        nbytes = 0;
        while (nbytes < PHASE_BYTES) begin
          add_random_frame(flen);
          nbytes += flen;
        end
      end
    end

    settle();
    if (err_count == 0)
      $display("packet_flow_hash_dispatch_top_test: clean");
    else
      $display("packet_flow_hash_dispatch_top_test: errors");
    $finish;
  end

endmodule
